FILE: rtl/point_mass_integrate_bounce_assert.svh
// Assertion macros for the point mass integrator checks
`ifndef POINT_MASS_INTEGRATE_BOUNCE_ASSERT_SVH
`define POINT_MASS_INTEGRATE_BOUNCE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define PMIB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define PMIB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pmib_pkg.sv
package pmib_pkg;

    localparam int DIV_STEPS = 32;
    localparam int S_IN      = 0;
    localparam int S_ACC     = DIV_STEPS + 1;
    localparam int S_VEL     = DIV_STEPS + 2;
    localparam int S_PMUL    = DIV_STEPS + 3;
    localparam int S_POS     = DIV_STEPS + 4;
    localparam int S_CLP     = DIV_STEPS + 5;
    localparam int S_REF     = DIV_STEPS + 6;
    localparam int S_OUT     = DIV_STEPS + 7;
    localparam int N_STAGES  = S_OUT + 1;

    localparam logic [2:0] REG_TIME_STEP   = 3'd0;
    localparam logic [2:0] REG_MIN_X       = 3'd1;
    localparam logic [2:0] REG_MIN_Y       = 3'd2;
    localparam logic [2:0] REG_MIN_Z       = 3'd3;
    localparam logic [2:0] REG_MAX_X       = 3'd4;
    localparam logic [2:0] REG_MAX_Y       = 3'd5;
    localparam logic [2:0] REG_MAX_Z       = 3'd6;
    localparam logic [2:0] REG_BOUNDS_EN   = 3'd7;

    localparam logic [16:0] TIME_STEP_RST  = 17'd1092;
    localparam logic [30:0] ONE_Q16        = 31'd65536;
    localparam logic signed [17:0] DAMP_XZ     = 18'sd58982;
    localparam logic signed [17:0] DAMP_XZ_NEG = -18'sd58982;
    localparam logic signed [17:0] DAMP_Y_NEG  = -18'sd52429;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic             fix;
    } t_pv;

    typedef struct packed {
        t_pv              pv;
        logic [2:0][31:0] frc;
        logic [30:0]      mass;
        logic             use_div;
    } t_dcar;

    function automatic logic [31:0] fn_sat32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] fn_scale(input logic [31:0] v,
                                             input logic signed [17:0] c);
        logic signed [31:0] sv;
        logic signed [49:0] pr;
        sv = v;
        pr = sv * c;
        return fn_sat32({{30{pr[49]}}, pr[49:16]});
    endfunction

    // one restoring step: returns {remainder, shifted word with new quotient bit}
    function automatic logic [62:0] fn_div_step(input logic [30:0] rem,
                                                input logic [31:0] w,
                                                input logic [30:0] m);
        logic [31:0] t;
        logic [31:0] d;
        logic [30:0] nr;
        logic        qb;
        t  = {rem, w[31]};
        d  = t - {1'b0, m};
        qb = (t >= {1'b0, m});
        nr = qb ? d[30:0] : t[30:0];
        return {nr, w[30:0], qb};
    endfunction

endpackage

FILE: rtl/point_mass_integrate_bounce.sv
// channel  | valid       | ready       | payload
// input    | i_in_valid  | o_in_ready  | i_pos_*, i_vel_*, i_force_*, i_point_mass, i_body_fixed
// output   | o_out_valid | i_out_ready | o_new_pos_*, o_new_vel_*
// config   | i_cfg_we    | -           | i_cfg_idx, i_cfg_data
// One transaction per cycle unless the output stalls; input register, 32 divider steps
// (one quotient bit each, three axes in parallel), then seven arithmetic stages.
// Synchronous active-low reset clears valid bits and bounds; the time step resets to 1092.
// A stage moves when it is empty or the stage after it moves; bubbles collapse.
module point_mass_integrate_bounce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    input  logic [31:0] i_force_x,
    input  logic [31:0] i_force_y,
    input  logic [31:0] i_force_z,
    input  logic [30:0] i_point_mass,
    input  logic        i_body_fixed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_new_pos_x,
    output logic [31:0] o_new_pos_y,
    output logic [31:0] o_new_pos_z,
    output logic [31:0] o_new_vel_x,
    output logic [31:0] o_new_vel_y,
    output logic [31:0] o_new_vel_z
);
    import pmib_pkg::*;

    logic [16:0]      r_time_step;
    logic [2:0][31:0] r_bmin;
    logic [2:0][31:0] r_bmax;
    logic             r_bounds_en;

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] c_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RST;
            r_bmin      <= '0;
            r_bmax      <= '0;
            r_bounds_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TIME_STEP: r_time_step  <= i_cfg_data[16:0];
                REG_MIN_X:     r_bmin[AX_X] <= i_cfg_data;
                REG_MIN_Y:     r_bmin[AX_Y] <= i_cfg_data;
                REG_MIN_Z:     r_bmin[AX_Z] <= i_cfg_data;
                REG_MAX_X:     r_bmax[AX_X] <= i_cfg_data;
                REG_MAX_Y:     r_bmax[AX_Y] <= i_cfg_data;
                REG_MAX_Z:     r_bmax[AX_Z] <= i_cfg_data;
                REG_BOUNDS_EN: r_bounds_en  <= i_cfg_data[0];
                default:       r_bounds_en  <= r_bounds_en;
            endcase
        end
    end

    always_comb begin
        c_en[N_STAGES-1] = !r_vld[N_STAGES-1] || i_out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            c_en[k] = !r_vld[k] || c_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (c_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (c_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready = c_en[S_IN];

    // input stage
    t_dcar r_in;

    always_ff @(posedge i_clk) begin
        if (c_en[S_IN]) begin
            r_in.pv.pos <= {i_pos_z, i_pos_y, i_pos_x};
            r_in.pv.vel <= {i_vel_z, i_vel_y, i_vel_x};
            r_in.pv.fix <= i_body_fixed;
            r_in.frc    <= {i_force_z, i_force_y, i_force_x};
            r_in.mass   <= i_point_mass;
            r_in.use_div <= (i_point_mass > ONE_Q16);
        end
    end

    // divider
    logic [2:0][30:0] c_rem0;
    logic [2:0][31:0] c_w0;

    always_comb begin
        logic [31:0] mag;
        for (int a = 0; a < 3; a++) begin
            mag       = r_in.frc[a][31] ? (32'd0 - r_in.frc[a]) : r_in.frc[a];
            c_rem0[a] = {15'd0, mag[31:16]};
            c_w0[a]   = {mag[15:0], 16'd0};
        end
    end

    t_dcar            r_dc   [1:DIV_STEPS];
    logic [2:0][30:0] r_rem  [1:DIV_STEPS];
    logic [2:0][31:0] r_w    [1:DIV_STEPS];
    t_dcar            c_dc_in  [1:DIV_STEPS];
    logic [2:0][30:0] c_rem_in [1:DIV_STEPS];
    logic [2:0][31:0] c_w_in   [1:DIV_STEPS];

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        logic [2:0][30:0] c_rem_nx;
        logic [2:0][31:0] c_w_nx;

        if (j == 1) begin : g_first
            assign c_dc_in[j]  = r_in;
            assign c_rem_in[j] = c_rem0;
            assign c_w_in[j]   = c_w0;
        end else begin : g_next
            assign c_dc_in[j]  = r_dc[j-1];
            assign c_rem_in[j] = r_rem[j-1];
            assign c_w_in[j]   = r_w[j-1];
        end

        always_comb begin
            logic [62:0] st;
            for (int a = 0; a < 3; a++) begin
                st          = fn_div_step(c_rem_in[j][a], c_w_in[j][a], c_dc_in[j].mass);
                c_rem_nx[a] = st[62:32];
                c_w_nx[a]   = st[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (c_en[j]) begin
                r_dc[j]  <= c_dc_in[j];
                r_rem[j] <= c_rem_nx;
                r_w[j]   <= c_w_nx;
            end
        end
    end

    // acceleration times dt
    t_pv                     r_acc_pv;
    logic signed [2:0][49:0] r_acc_prod;
    logic [2:0][49:0]        c_acc_prod;

    always_comb begin
        logic [31:0]        q;
        logic signed [31:0] acc;
        logic signed [17:0] sdt;
        logic signed [49:0] pr;
        t_dcar              d;
        d   = r_dc[DIV_STEPS];
        sdt = {1'b0, r_time_step};
        for (int a = 0; a < 3; a++) begin
            q   = r_w[DIV_STEPS][a];
            if (d.use_div) begin
                acc = d.frc[a][31] ? (32'd0 - q) : q;
            end else begin
                acc = d.frc[a];
            end
            pr            = acc * sdt;
            c_acc_prod[a] = pr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[S_ACC]) begin
            r_acc_pv   <= r_dc[DIV_STEPS].pv;
            r_acc_prod <= c_acc_prod;
        end
    end

    // velocity update
    t_pv r_vel_pv;
    t_pv c_vel_pv;

    always_comb begin
        logic [63:0] s;
        c_vel_pv = r_acc_pv;
        for (int a = 0; a < 3; a++) begin
            s = {{32{r_acc_pv.vel[a][31]}}, r_acc_pv.vel[a]}
              + {{30{r_acc_prod[a][49]}}, r_acc_prod[a][49:16]};
            if (!r_acc_pv.fix) begin
                c_vel_pv.vel[a] = fn_sat32(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[S_VEL]) begin
            r_vel_pv <= c_vel_pv;
        end
    end

    // velocity times dt
    t_pv              r_pm_pv;
    logic [2:0][49:0] r_pm_prod;
    logic [2:0][49:0] c_pm_prod;

    always_comb begin
        logic signed [31:0] sv;
        logic signed [17:0] sdt;
        logic signed [49:0] pr;
        sdt = {1'b0, r_time_step};
        for (int a = 0; a < 3; a++) begin
            sv           = r_vel_pv.vel[a];
            pr           = sv * sdt;
            c_pm_prod[a] = pr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[S_PMUL]) begin
            r_pm_pv   <= r_vel_pv;
            r_pm_prod <= c_pm_prod;
        end
    end

    // position update
    t_pv r_pos_pv;
    t_pv c_pos_pv;

    always_comb begin
        logic [63:0] s;
        c_pos_pv = r_pm_pv;
        for (int a = 0; a < 3; a++) begin
            s = {{32{r_pm_pv.pos[a][31]}}, r_pm_pv.pos[a]}
              + {{30{r_pm_prod[a][49]}}, r_pm_prod[a][49:16]};
            if (!r_pm_pv.fix) begin
                c_pos_pv.pos[a] = fn_sat32(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[S_POS]) begin
            r_pos_pv <= c_pos_pv;
        end
    end

    // clamp to the box
    t_pv        r_clp_pv;
    logic [2:0] r_clp_hit;
    t_pv        c_clp_pv;
    logic [2:0] c_clp_hit;

    always_comb begin
        logic act;
        logic lo;
        logic hi;
        act      = r_bounds_en && !r_pos_pv.fix;
        c_clp_pv = r_pos_pv;
        for (int a = 0; a < 3; a++) begin
            lo = $signed(r_pos_pv.pos[a]) < $signed(r_bmin[a]);
            hi = $signed(r_pos_pv.pos[a]) > $signed(r_bmax[a]);
            c_clp_hit[a] = act && (lo || hi);
            if (act && lo) begin
                c_clp_pv.pos[a] = r_bmin[a];
            end else if (act && hi) begin
                c_clp_pv.pos[a] = r_bmax[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[S_CLP]) begin
            r_clp_pv  <= c_clp_pv;
            r_clp_hit <= c_clp_hit;
        end
    end

    // reflect
    t_pv  r_ref_pv;
    logic r_ref_hit_y;
    t_pv  c_ref_pv;

    always_comb begin
        c_ref_pv = r_clp_pv;
        if (r_clp_hit[AX_X]) begin
            c_ref_pv.vel[AX_X] = fn_scale(r_clp_pv.vel[AX_X], DAMP_XZ_NEG);
        end
        if (r_clp_hit[AX_Z]) begin
            c_ref_pv.vel[AX_Z] = fn_scale(r_clp_pv.vel[AX_Z], DAMP_XZ_NEG);
        end
        if (r_clp_hit[AX_Y]) begin
            c_ref_pv.vel[AX_Y] = fn_scale(r_clp_pv.vel[AX_Y], DAMP_Y_NEG);
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[S_REF]) begin
            r_ref_pv    <= c_ref_pv;
            r_ref_hit_y <= r_clp_hit[AX_Y];
        end
    end

    // damp x and z after a floor or ceiling bounce
    t_pv r_out_pv;
    t_pv c_out_pv;

    always_comb begin
        c_out_pv = r_ref_pv;
        if (r_ref_hit_y) begin
            c_out_pv.vel[AX_X] = fn_scale(r_ref_pv.vel[AX_X], DAMP_XZ);
            c_out_pv.vel[AX_Z] = fn_scale(r_ref_pv.vel[AX_Z], DAMP_XZ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[S_OUT]) begin
            r_out_pv <= c_out_pv;
        end
    end

    assign o_out_valid = r_vld[S_OUT];
    assign o_new_pos_x = r_out_pv.pos[AX_X];
    assign o_new_pos_y = r_out_pv.pos[AX_Y];
    assign o_new_pos_z = r_out_pv.pos[AX_Z];
    assign o_new_vel_x = r_out_pv.vel[AX_X];
    assign o_new_vel_y = r_out_pv.vel[AX_Y];
    assign o_new_vel_z = r_out_pv.vel[AX_Z];

endmodule

FILE: rtl/pmib_checker.sv
`include "point_mass_integrate_bounce_assert.svh"

module pmib_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready
);
    import pmib_pkg::*;

    logic c_out_stall;
    logic c_in_idle;

    assign c_out_stall = o_out_valid && !i_out_ready;
    assign c_in_idle   = !i_in_valid && (N_STAGES > 0);

    `PMIB_ASSERT_NEXT(a_out_hold, c_out_stall, o_out_valid, "output transaction dropped")
    `PMIB_ASSERT_NOW(a_empty_ready, !o_out_valid, o_in_ready, "stall with empty output")
    `PMIB_ASSERT_NOW(a_drain_ready, i_out_ready, o_in_ready, "stall while output drains")
    `PMIB_ASSERT_NOW(a_idle_ready, c_in_idle && !o_out_valid, o_in_ready, "idle not ready")

endmodule

bind point_mass_integrate_bounce pmib_checker u_pmib_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pmib_pkg::*;

    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] pos_x, pos_y, pos_z;
        logic [31:0] vel_x, vel_y, vel_z;
        logic [31:0] frc_x, frc_y, frc_z;
        logic [30:0] mass;
        logic        fixed;
    } point_t;

    typedef struct packed {
        logic [31:0] pos_x, pos_y, pos_z;
        logic [31:0] vel_x, vel_y, vel_z;
    } motion_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic [31:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic [31:0] i_vel_x = 0, i_vel_y = 0, i_vel_z = 0;
    logic [31:0] i_force_x = 0, i_force_y = 0, i_force_z = 0;
    logic [30:0] i_point_mass = 0;
    logic i_body_fixed = 0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic [31:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic [31:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;

    point_mass_integrate_bounce DUT (.*);

    always #5 i_clk = ~i_clk;

    logic [16:0] dt_q;
    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    logic box_on;

    motion_t expected_motion [$];
    int fail_count = 0;
    int idle_cycles = 0;
    bit sender_idle_en = 1;
    bit receiver_idle_en = 1;
    int hold_off_cycles = 0;

    function automatic logic signed [63:0] floor_q16(input logic signed [63:0] x);
        return x >>> 16;
    endfunction

    function automatic logic signed [31:0] sat_word(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fff_ffff;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] damp(input logic signed [31:0] v,
                                                 input longint c);
        longint p;
        p = longint'(v) * c;
        return sat_word(floor_q16(p));
    endfunction

    function automatic motion_t advance_point(input point_t pt);
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        logic signed [31:0] f [3];
        longint a, m, c;
        bit hit;
        motion_t r;
        p = '{pt.pos_x, pt.pos_y, pt.pos_z};
        v = '{pt.vel_x, pt.vel_y, pt.vel_z};
        f = '{pt.frc_x, pt.frc_y, pt.frc_z};
        m = longint'({33'd0, pt.mass});
        if (!pt.fixed) begin
            for (int i = 0; i < 3; i++) begin
                a = longint'(f[i]);
                if (m > 65536) a = (a * 65536) / m;
                v[i] = sat_word(longint'(v[i]) + floor_q16(a * longint'(dt_q)));
                p[i] = sat_word(longint'(p[i]) + floor_q16(longint'(v[i]) * longint'(dt_q)));
            end
            if (box_on) begin
                hit = 0;
                foreach (p[i]) begin
                    c = (i == AX_Y) ? -52429 : -58982;
                    if (p[i] < box_lo[i]) begin
                        p[i] = box_lo[i];
                        v[i] = damp(v[i], c);
                        if (i == AX_Y) hit = 1;
                    end else if (p[i] > box_hi[i]) begin
                        p[i] = box_hi[i];
                        v[i] = damp(v[i], c);
                        if (i == AX_Y) hit = 1;
                    end
                end
                if (hit) begin
                    v[AX_X] = damp(v[AX_X], 58982);
                    v[AX_Z] = damp(v[AX_Z], 58982);
                end
            end
        end
        r = '{p[0], p[1], p[2], v[0], v[1], v[2]};
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_TIME_STEP: dt_q = data[16:0];
            REG_MIN_X: box_lo[AX_X] = data;
            REG_MIN_Y: box_lo[AX_Y] = data;
            REG_MIN_Z: box_lo[AX_Z] = data;
            REG_MAX_X: box_hi[AX_X] = data;
            REG_MAX_Y: box_hi[AX_Y] = data;
            REG_MAX_Z: box_hi[AX_Z] = data;
            REG_BOUNDS_EN: box_on = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 0;
        while (expected_motion.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz, input bit on);
        wait_drained();
        write_reg(REG_MIN_X, lx);
        write_reg(REG_MIN_Y, ly);
        write_reg(REG_MIN_Z, lz);
        write_reg(REG_MAX_X, hx);
        write_reg(REG_MAX_Y, hy);
        write_reg(REG_MAX_Z, hz);
        write_reg(REG_BOUNDS_EN, on);
    endtask

    task automatic send_point(input point_t pt);
        if (sender_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        {i_pos_x, i_pos_y, i_pos_z, i_vel_x, i_vel_y, i_vel_z,
         i_force_x, i_force_y, i_force_z, i_point_mass, i_body_fixed} <= pt;
        expected_motion.push_back(advance_point(pt));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [31:0] rand_word(input int mode);
        case (mode)
            0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            1: return $urandom_range(0, 400000) - 200000;
            2: return $urandom_range(0, 40000000) - 20000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t pt;
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 4) ? 1 : (mode < 7) ? 2 : (mode < 8) ? 0 : 3;
        pt.pos_x = rand_word(mode);
        pt.pos_y = rand_word(mode);
        pt.pos_z = rand_word(mode);
        pt.vel_x = rand_word($urandom_range(1, 3));
        pt.vel_y = rand_word($urandom_range(1, 3));
        pt.vel_z = rand_word($urandom_range(1, 3));
        pt.frc_x = rand_word($urandom_range(0, 3));
        pt.frc_y = rand_word($urandom_range(0, 3));
        pt.frc_z = rand_word($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0: pt.mass = $urandom_range(0, 65537);
            1: pt.mass = $urandom_range(65536, 1000000);
            2: pt.mass = $urandom & 31'h7fff_ffff;
            default: pt.mass = $urandom_range(1, 16) << 14;
        endcase
        pt.fixed = ($urandom_range(0, 9) == 0);
        return pt;
    endfunction

    task automatic test_directed();
        point_t pt;
        set_box(32'hfff6_0000, 32'h0, 32'hfff6_0000, 32'h000a_0000, 32'h0014_0000,
                32'h000a_0000, 1);
        write_reg(REG_TIME_STEP, 1092);
        pt = '{0, 32'h0001_0000, 0, 0, 32'hfff0_0000, 0, 0, 32'hfff6_0000, 0, 65536, 0};
        send_point(pt);
        pt = '{32'h0009_ff00, 32'h0013_0000, 32'hfff6_1000, 32'h0100_0000, 32'h0100_0000,
               32'hff00_0000, 0, 0, 0, 65537, 0};
        send_point(pt);
        pt = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 1};
        send_point(pt);
        pt.fixed = 0;
        send_point(pt);
        pt.mass = 0;
        send_point(pt);
        pt = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
               32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 0};
        send_point(pt);
        set_box(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'hfffb_0000, 32'hfffb_0000,
                32'hfffb_0000, 1);
        send_point('{0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, 0, 0});
        send_point('{32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 5, -5, 7, 1, -1, 3,
                     131072, 0});
        wait_drained();
        write_reg(REG_TIME_STEP, 32'h0001_ffff);
        write_reg(REG_BOUNDS_EN, 0);
        send_point('{1, 2, 3, 32'h4000_0000, 32'hc000_0000, 9, 32'h7000_0000, -3, 0, 196608, 0});
        send_point(rand_point());
        wait_drained();
        write_reg(REG_TIME_STEP, 0);
        send_point(rand_point());
        send_point(rand_point());
        wait_drained();
        write_reg(REG_TIME_STEP, 32'h0001_0000);
        send_point(rand_point());
        send_point(rand_point());
    endtask

    task automatic test_random_settings(input int n);
        logic [31:0] lo, hi;
        for (int s = 0; s < 4; s++) begin
            wait_drained();
            write_reg(REG_TIME_STEP, (s == 3) ? $urandom & 32'h1ffff : $urandom_range(0, 8192));
            lo = -($urandom_range(1, 200) << 16);
            hi = $urandom_range(1, 200) << 16;
            set_box(lo, lo + 32'h0001_0000, lo, hi, hi, hi, s != 1);
            if (s == 2) write_reg(REG_MIN_Y, $urandom);
            for (int i = 0; i < n; i++) send_point(rand_point());
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_off_cycles = 150;
        for (int i = 0; i < 100; i++) send_point(rand_point());
        wait_drained();
        for (int i = 0; i < 20; i++) send_point(rand_point());
    endtask

    task automatic test_streaming();
        wait_drained();
        sender_idle_en = 0;
        receiver_idle_en = 0;
        for (int i = 0; i < 100; i++) send_point(rand_point());
    endtask

    always @(posedge i_clk) begin
        motion_t got, exp_m;
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_new_pos_x, o_new_pos_y, o_new_pos_z,
                        o_new_vel_x, o_new_vel_y, o_new_vel_z};
                if (expected_motion.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end else begin
                    exp_m = expected_motion.pop_front();
                    if (got.pos_x !== exp_m.pos_x) begin
                        $display("%0t: pos_x exp %h got %h", $time, exp_m.pos_x, got.pos_x);
                        fail_count++;
                    end
                    if (got.pos_y !== exp_m.pos_y) begin
                        $display("%0t: pos_y exp %h got %h", $time, exp_m.pos_y, got.pos_y);
                        fail_count++;
                    end
                    if (got.pos_z !== exp_m.pos_z) begin
                        $display("%0t: pos_z exp %h got %h", $time, exp_m.pos_z, got.pos_z);
                        fail_count++;
                    end
                    if (got.vel_x !== exp_m.vel_x) begin
                        $display("%0t: vel_x exp %h got %h", $time, exp_m.vel_x, got.vel_x);
                        fail_count++;
                    end
                    if (got.vel_y !== exp_m.vel_y) begin
                        $display("%0t: vel_y exp %h got %h", $time, exp_m.vel_y, got.vel_y);
                        fail_count++;
                    end
                    if (got.vel_z !== exp_m.vel_z) begin
                        $display("%0t: vel_z exp %h got %h", $time, exp_m.vel_z, got.vel_z);
                        fail_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_out_ready <= 0;
            end else if (idle_cycles > 0) begin
                idle_cycles <= idle_cycles - 1;
                i_out_ready <= 0;
            end else if (receiver_idle_en && $urandom_range(0, 7) == 0) begin
                idle_cycles <= $urandom_range(1, 18) - 1;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    int stuck_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n
            || (!i_in_valid && expected_motion.size() == 0)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        dt_q = TIME_STEP_RST;
        box_lo = '{0, 0, 0};
        box_hi = '{0, 0, 0};
        box_on = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_random_settings(200);
        test_backpressure();
        test_streaming();
        wait_drained();
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
